### hdl/fecq_pkg.sv
// Shared constants, types and the event merge rule for the event coalescing queue.
package fecq_pkg;

  // Default sizes
  localparam int FECQ_DEPTH        = 16;
  localparam int FECQ_KEY_WIDTH    = 32;
  localparam int FECQ_HANDLE_WIDTH = 16;

  // Event codes
  localparam int EV_WIDTH = 3;
  typedef logic [EV_WIDTH-1:0] ev_code_t;
  localparam ev_code_t EV_ADDED       = 3'd0;
  localparam ev_code_t EV_MODIFIED    = 3'd1;
  localparam ev_code_t EV_REMOVED     = 3'd2;
  localparam ev_code_t EV_RENAMED_OLD = 3'd3;
  localparam ev_code_t EV_RENAMED_NEW = 3'd4;

  // Request operations
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Result kinds and actions
  localparam logic KIND_FLUSHED = 1'b0;
  localparam logic KIND_DROPPED = 1'b1;
  localparam logic ACT_UPDATE   = 1'b0;
  localparam logic ACT_DELETE   = 1'b1;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic push;     // push request accepted this cycle
    logic shift;    // flush: every cell takes its upper neighbour's entry
    logic hit_any;  // pushed key already held by some cell
  } fecq_ctl_t;

  // Merge an incoming event into a stored one
  function automatic ev_code_t fecq_merge(input ev_code_t prev, input ev_code_t incoming);
    ev_code_t inc;
    ev_code_t res;
    inc = incoming;
    res = incoming;
    if (incoming == EV_REMOVED || incoming == EV_RENAMED_OLD) begin
      res = incoming;
    end else begin
      if (incoming == EV_RENAMED_NEW) begin
        inc = EV_ADDED;
      end
      if (prev == EV_REMOVED) begin
        res = prev;
      end else if (prev == EV_ADDED && inc == EV_MODIFIED) begin
        res = prev;
      end else begin
        res = inc;
      end
    end
    return res;
  endfunction

  // Delete for removal or old-name rename, update otherwise
  function automatic logic fecq_action(input ev_code_t ev);
    return (ev == EV_REMOVED || ev == EV_RENAMED_OLD) ? ACT_DELETE : ACT_UPDATE;
  endfunction

endpackage

### hdl/fecq_cell.sv
// One entry of the coalescing queue: compare, merge, append and shift-down.
module fecq_cell #(
  parameter int KEY_WIDTH    = fecq_pkg::FECQ_KEY_WIDTH,
  parameter int HANDLE_WIDTH = fecq_pkg::FECQ_HANDLE_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fecq_pkg::fecq_ctl_t        ctl,
  input  logic [KEY_WIDTH-1:0]       in_key,
  input  fecq_pkg::ev_code_t         in_ev,
  input  logic [HANDLE_WIDTH-1:0]    in_path,
  input  logic                       prev_valid,
  input  logic                       up_valid,
  input  logic [KEY_WIDTH-1:0]       up_key,
  input  fecq_pkg::ev_code_t         up_ev,
  input  logic [HANDLE_WIDTH-1:0]    up_path,
  output logic                       valid,
  output logic [KEY_WIDTH-1:0]       key,
  output fecq_pkg::ev_code_t         ev,
  output logic [HANDLE_WIDTH-1:0]    path,
  output logic                       match
);
  import fecq_pkg::*;

  logic                    valid_r;
  logic [KEY_WIDTH-1:0]    key_r;
  ev_code_t                ev_r;
  logic [HANDLE_WIDTH-1:0] path_r;
  logic                    append;

  // Key compare and append slot (first empty cell)
  assign match  = valid_r && (key_r == in_key);
  assign append = ctl.push && !ctl.hit_any && !valid_r && prev_valid;

  // Occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= up_valid;
    end else if (append) begin
      valid_r <= 1'b1;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r  <= up_key;
      ev_r   <= up_ev;
      path_r <= up_path;
    end else if (ctl.push && match) begin
      ev_r   <= fecq_merge(ev_r, in_ev);
      path_r <= in_path;
    end else if (append) begin
      key_r  <= in_key;
      ev_r   <= in_ev;
      path_r <= in_path;
    end
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign ev    = ev_r;
  assign path  = path_r;

endmodule

### hdl/file_event_coalescing_queue.sv
// Top level of the file event coalescing queue: a row of entry cells plus result register.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------------
//   in_      | start & !busy             | in_operation, in_item_key, in_event_code,
//            |                           | in_path_handle
//   out_     | out_strobe (one cycle)    | out_result_kind, out_action, out_entry_key,
//            |                           | out_entry_path, out_last_result
//
// On a push all cells compare the key at once; a drop result shows the cycle after.
// A flush holds busy while entries remain in the row, one entry leaving cell 0 each
// cycle as the row shifts down; each result appears the cycle after its entry leaves
// cell 0. Reset empties the row. The receiver cannot stall results.
module file_event_coalescing_queue #(
  parameter int DEPTH        = fecq_pkg::FECQ_DEPTH,
  parameter int KEY_WIDTH    = fecq_pkg::FECQ_KEY_WIDTH,
  parameter int HANDLE_WIDTH = fecq_pkg::FECQ_HANDLE_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_operation,
  input  logic [KEY_WIDTH-1:0]    in_item_key,
  input  logic [2:0]              in_event_code,
  input  logic [HANDLE_WIDTH-1:0] in_path_handle,
  output logic                    out_strobe,
  output logic                    out_result_kind,
  output logic                    out_action,
  output logic [KEY_WIDTH-1:0]    out_entry_key,
  output logic [HANDLE_WIDTH-1:0] out_entry_path,
  output logic                    out_last_result
);
  import fecq_pkg::*;

  logic                    accept;
  logic                    flush_r;
  fecq_ctl_t               ctl;
  logic                    drop;

  logic [DEPTH-1:0]        c_valid;
  logic [DEPTH-1:0]        c_match;
  logic [KEY_WIDTH-1:0]    c_key  [DEPTH];
  ev_code_t                c_ev   [DEPTH];
  logic [HANDLE_WIDTH-1:0] c_path [DEPTH];

  logic                    out_strobe_r;
  logic                    out_kind_r;
  logic                    out_action_r;
  logic [KEY_WIDTH-1:0]    out_key_r;
  logic [HANDLE_WIDTH-1:0] out_path_r;
  logic                    out_last_r;

  assign busy   = flush_r;
  assign accept = start && !flush_r;

  // Broadcast control
  always_comb begin
    ctl.push    = accept && (in_operation == OP_PUSH);
    ctl.shift   = flush_r;
    ctl.hit_any = |c_match;
  end

  // New key with the row full
  assign drop = ctl.push && !ctl.hit_any && c_valid[DEPTH-1];

  // Row of cells; entry 0 is oldest, flush shifts towards it
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    prv_v;
    logic                    up_v;
    logic [KEY_WIDTH-1:0]    up_k;
    ev_code_t                up_e;
    logic [HANDLE_WIDTH-1:0] up_p;

    if (i == 0) begin : g_first
      assign prv_v = 1'b1;
    end else begin : g_rest
      assign prv_v = c_valid[i-1];
    end

    if (i == DEPTH-1) begin : g_top
      assign up_v = 1'b0;
      assign up_k = '0;
      assign up_e = EV_ADDED;
      assign up_p = '0;
    end else begin : g_mid
      assign up_v = c_valid[i+1];
      assign up_k = c_key[i+1];
      assign up_e = c_ev[i+1];
      assign up_p = c_path[i+1];
    end

    fecq_cell #(
      .KEY_WIDTH    (KEY_WIDTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .in_key     (in_item_key),
      .in_ev      (in_event_code),
      .in_path    (in_path_handle),
      .prev_valid (prv_v),
      .up_valid   (up_v),
      .up_key     (up_k),
      .up_ev      (up_e),
      .up_path    (up_p),
      .valid      (c_valid[i]),
      .key        (c_key[i]),
      .ev         (c_ev[i]),
      .path       (c_path[i]),
      .match      (c_match[i])
    );
  end

  // Flush sequencing: runs while cell 0 holds an entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r <= 1'b0;
    end else if (flush_r) begin
      flush_r <= c_valid[1];
    end else if (accept && in_operation == OP_FLUSH) begin
      flush_r <= c_valid[0];
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= flush_r || drop;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (flush_r) begin
      out_kind_r   <= KIND_FLUSHED;
      out_action_r <= fecq_action(c_ev[0]);
      out_key_r    <= c_key[0];
      out_path_r   <= c_path[0];
      out_last_r   <= !c_valid[1];
    end else if (drop) begin
      out_kind_r   <= KIND_DROPPED;
      out_action_r <= ACT_UPDATE;
      out_key_r    <= in_item_key;
      out_path_r   <= in_path_handle;
      out_last_r   <= 1'b1;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_result_kind = out_kind_r;
  assign out_action      = out_action_r;
  assign out_entry_key   = out_key_r;
  assign out_entry_path  = out_path_r;
  assign out_last_result = out_last_r;

endmodule

### hdl/fecq_checker.sv
// Port-level checks for the event coalescing queue, bound to the top level.
module fecq_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_operation,
  input logic out_strobe,
  input logic out_result_kind,
  input logic out_last_result
);
  import fecq_pkg::*;

  // A drop is always the only result of its push
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result_kind == KIND_DROPPED |-> out_last_result)
    else $error("drop result without last mark");

  // A drop follows an accepted push in the next cycle
  a_drop_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result_kind == KIND_DROPPED |->
      $past(start && !busy && in_operation == OP_PUSH))
    else $error("drop result without a push request");

  // A flush stream runs without gaps until its last entry
  a_flush_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result_kind == KIND_FLUSHED && !out_last_result |=>
      out_strobe && out_result_kind == KIND_FLUSHED)
    else $error("flush stream broken before last entry");

  // Busy ends together with the last flushed entry
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe && out_last_result && out_result_kind == KIND_FLUSHED)
    else $error("busy dropped without last flushed entry");

endmodule

bind file_event_coalescing_queue fecq_checker u_fecq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_operation    (in_operation),
  .out_strobe      (out_strobe),
  .out_result_kind (out_result_kind),
  .out_last_result (out_last_result)
);

### tb/tb_top.sv
// Self-checking testbench for the file event coalescing queue: scoreboard class and request driver.
module tb_top;
  import fecq_pkg::*;

  localparam int DEPTH          = FECQ_DEPTH;
  localparam int KW             = FECQ_KEY_WIDTH;
  localparam int HW             = FECQ_HANDLE_WIDTH;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int POOL_SIZE      = 40;

  // Codes outside the defined set; the block stores them as given
  localparam ev_code_t EV_SPARE_5 = 3'd5;
  localparam ev_code_t EV_SPARE_6 = 3'd6;
  localparam ev_code_t EV_SPARE_7 = 3'd7;

  typedef struct packed {
    logic          kind;
    logic          action;
    logic [KW-1:0] key;
    logic [HW-1:0] path;
    logic          last;
  } table_result_t;

  // Mirror of the pending table plus the results it owes
  class coalesce_scoreboard;
    logic [KW-1:0] held_key   [DEPTH];
    ev_code_t      held_event [DEPTH];
    logic [HW-1:0] held_path  [DEPTH];
    int            held_count;
    table_result_t due_results[$];
    int            fail_count;

    function new();
      held_count = 0;
      fail_count = 0;
    endfunction

    function ev_code_t merged_event(ev_code_t prev, ev_code_t incoming);
      ev_code_t eff;
      if (incoming == EV_REMOVED || incoming == EV_RENAMED_OLD) return incoming;
      eff = (incoming == EV_RENAMED_NEW) ? EV_ADDED : incoming;
      if (prev == EV_REMOVED) return prev;
      if (prev == EV_ADDED && eff == EV_MODIFIED) return prev;
      return eff;
    endfunction

    // Accepted request: update the mirror and queue whatever it produces
    function void note_request(logic op, logic [KW-1:0] key, ev_code_t ev,
                               logic [HW-1:0] path);
      table_result_t r;
      if (op == OP_FLUSH) begin
        for (int i = 0; i < held_count; i++) begin
          r.kind   = KIND_FLUSHED;
          r.action = (held_event[i] == EV_REMOVED || held_event[i] == EV_RENAMED_OLD)
                     ? ACT_DELETE : ACT_UPDATE;
          r.key    = held_key[i];
          r.path   = held_path[i];
          r.last   = (i == held_count - 1);
          due_results.push_back(r);
        end
        held_count = 0;
        return;
      end
      for (int i = 0; i < held_count; i++) begin
        if (held_key[i] == key) begin
          held_event[i] = merged_event(held_event[i], ev);
          held_path[i]  = path;
          return;
        end
      end
      if (held_count >= DEPTH) begin
        r.kind   = KIND_DROPPED;
        r.action = ACT_UPDATE;
        r.key    = key;
        r.path   = path;
        r.last   = 1'b1;
        due_results.push_back(r);
        return;
      end
      held_key[held_count]   = key;
      held_event[held_count] = ev;
      held_path[held_count]  = path;
      held_count++;
    endfunction

    function void report(string what, table_result_t want, table_result_t got);
      fail_count++;
      if (fail_count <= 10)
        $display("%s: exp kind=%0d act=%0d key=%h path=%h last=%0d | %s%0d %s%0d %s%h %s%h %s%0d",
                 what, want.kind, want.action, want.key, want.path, want.last,
                 "got kind=", got.kind, "act=", got.action, "key=", got.key,
                 "path=", got.path, "last=", got.last);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      want = '0;
      if (due_results.size() == 0) begin
        report("unexpected result", want, got);
        return;
      end
      want = due_results[0];
      due_results.delete(0);
      if (want.kind !== got.kind || want.action !== got.action || want.key !== got.key ||
          want.path !== got.path || want.last !== got.last)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic          in_operation = OP_PUSH;
  logic [KW-1:0] in_item_key = '0;
  logic [2:0]    in_event_code = EV_ADDED;
  logic [HW-1:0] in_path_handle = '0;
  logic          out_strobe;
  logic          out_result_kind;
  logic          out_action;
  logic [KW-1:0] out_entry_key;
  logic [HW-1:0] out_entry_path;
  logic          out_last_result;

  coalesce_scoreboard tracker;
  table_result_t      seen;
  int                 quiet_cycles = 0;
  int                 idle_pct = 0;
  logic [KW-1:0]      key_pool [POOL_SIZE];

  file_event_coalescing_queue u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_item_key    (in_item_key),
    .in_event_code  (in_event_code),
    .in_path_handle (in_path_handle),
    .out_strobe     (out_strobe),
    .out_result_kind(out_result_kind),
    .out_action     (out_action),
    .out_entry_key  (out_entry_key),
    .out_entry_path (out_entry_path),
    .out_last_result(out_last_result)
  );

  always #5 clk = ~clk;

  // Monitor: results are checked before the same edge's request is noted
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      seen.kind   = out_result_kind;
      seen.action = out_action;
      seen.key    = out_entry_key;
      seen.path   = out_entry_path;
      seen.last   = out_last_result;
      tracker.check_result(seen);
    end
    if (rst_n && start && !busy)
      tracker.note_request(in_operation, in_item_key, ev_code_t'(in_event_code),
                           in_path_handle);
    // watchdog on cycles with no traffic either way
    if ((rst_n && start && !busy) || (rst_n && out_strobe)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one request, with an optional idle gap first, and hold it until taken
  task automatic issue_request(input logic op, input logic [KW-1:0] key,
                               input ev_code_t ev, input logic [HW-1:0] path);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_item_key    <= key;
    in_event_code  <= ev;
    in_path_handle <= path;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every owed result has come out
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (tracker.due_results.size() != 0);
  endtask

  task automatic push_event(input logic [KW-1:0] key, input ev_code_t ev,
                            input logic [HW-1:0] path);
    issue_request(OP_PUSH, key, ev, path);
  endtask

  task automatic flush_table();
    issue_request(OP_FLUSH, KW'($urandom), ev_code_t'($urandom_range(0, 7)), HW'($urandom));
  endtask

  // Random traffic drawn from a key pool so that merges and overflow happen
  task automatic run_random(input int n_items, input int idle, input int pool_n,
                            input int flush_odds);
    logic [KW-1:0] key;
    ev_code_t      ev;
    idle_pct = idle;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(1, flush_odds) == 1) begin
        flush_table();
      end else begin
        key = ($urandom_range(0, 9) == 0) ? KW'($urandom)
                                          : key_pool[$urandom_range(0, pool_n - 1)];
        ev  = ($urandom_range(0, 9) == 0) ? ev_code_t'($urandom_range(5, 7))
                                          : ev_code_t'($urandom_range(0, 4));
        push_event(key, ev, HW'($urandom));
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty flush, merge rules, spare codes, overflow, full flush
    idle_pct = 0;
    flush_table();
    push_event(32'h0000_0000, EV_ADDED, 16'h0000);
    push_event(32'h0000_0000, EV_MODIFIED, 16'h1234);      // added then modified stays added
    push_event(32'hFFFF_FFFF, EV_RENAMED_NEW, 16'hFFFF);   // fresh new-name rename kept as is
    push_event(32'hFFFF_FFFF, EV_MODIFIED, 16'h00FF);
    push_event(32'hFFFF_FFFF, EV_RENAMED_NEW, 16'hFF00);   // new-name rename merges as added
    push_event(32'h1111_0001, EV_REMOVED, 16'h5555);
    push_event(32'h1111_0001, EV_RENAMED_NEW, 16'hAAAA);   // removal survives
    push_event(32'h1111_0002, EV_MODIFIED, 16'h0F0F);
    push_event(32'h1111_0002, EV_RENAMED_OLD, 16'hF0F0);   // old-name rename wins
    push_event(32'h1111_0003, EV_SPARE_5, 16'h0001);
    push_event(32'h1111_0003, EV_SPARE_7, 16'h0002);
    push_event(32'h1111_0004, EV_SPARE_6, 16'h8001);
    for (int i = 0; i < DEPTH - 6; i++)
      push_event(KW'(32'hA5A5_0000 + i), ev_code_t'(i % 5), HW'(i));
    push_event(32'h5A5A_5A5A, EV_ADDED, 16'hBEEF);         // table full: dropped
    push_event(32'h0000_0000, EV_RENAMED_NEW, 16'h8000);   // merge still allowed when full
    flush_table();
    push_event(32'h0F0F_0F0F, EV_REMOVED, 16'h7FFF);
    flush_table();
    drain_results();

    run_random(35, 0, 8, 6);
    run_random(35, 48, 24, 10);
    drain_results();
    run_random(35, 0, 40, 25);
    run_random(35, 25, 20, 12);

    start <= 1'b0;
    do @(posedge clk); while (tracker.due_results.size() != 0);
    repeat (4) @(posedge clk);
    if (tracker.due_results.size() != 0) begin
      tracker.fail_count += tracker.due_results.size();
      $display("%0d expected results never arrived", tracker.due_results.size());
    end
    if (tracker.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
